[hdl/svt_pkg.sv]
// Shared types, constants and helper functions of the sparse voxel tree store.
// No dependencies; used by every file under hdl but svt_ram.
package svt_pkg;

  localparam int MaxLevels   = 5;
  localparam int NodeCap     = 4096;
  localparam int Children    = 64;
  localparam int NodeW       = $clog2(NodeCap);       // node index
  localparam int UsedW       = NodeW + 1;             // node count / base with "none"
  localparam int LvW         = $clog2(MaxLevels + 1);
  localparam int ChildW      = $clog2(Children);
  localparam int CoordW      = 10;
  localparam int ResW        = 11;
  localparam int MatW        = 32;
  localparam int DensW       = 16;
  localparam int InW         = 80;
  localparam int OutW        = 56;
  localparam logic [UsedW-1:0] NoChild  = '1;
  localparam logic [UsedW-1:0] FullMark = UsedW'(NodeCap - Children);
  localparam logic [ResW-1:0]  ResReset = ResW'(1024);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_DONE,
    RES_IGNORED,
    RES_FULL,
    RES_HIT,
    RES_MISS
  } res_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_MASK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;        // capture input beat
    logic root_init;   // write empty root, nodes_used = 1
    logic capture;     // record path node/child/mask at current level
    logic alloc;       // point node at fresh child block
    logic clr_step;    // clear one child entry
    logic alloc_done;  // step into freshly allocated child
    logic advance;     // step into existing child
    logic leaf_wr;     // write material and density at leaf
    logic mask_step;   // set one mask bit along the path
    logic set_res;     // latch result
    res_t res;
    logic push;        // move result into output register
  } svt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad_insert;
    logic out_of_bounds;
    logic lv_end;
    logic depth_zero;
    logic no_base;
    logic pool_full;
    logic miss;
    logic hit;
    logic clr_last;
    logic mask_last;
    logic out_free;
  } svt_stat_t;

  // Least depth whose power of four covers the resolution, capped
  function automatic logic [LvW-1:0] level_count(input logic [ResW-1:0] res);
    logic [2*MaxLevels:0] sz;
    logic [LvW-1:0]       d;
    sz = (2*MaxLevels+1)'(1);
    d  = '0;
    for (int i = 0; i < MaxLevels; i++) begin
      if (sz < (2*MaxLevels+1)'(res)) begin
        sz = sz << 2;
        d  = d + 1'b1;
      end
    end
    return d;
  endfunction

  // Morton-style 6-bit child index for one level
  function automatic logic [ChildW-1:0] child_index(
    input logic [CoordW-1:0] x, input logic [CoordW-1:0] y, input logic [CoordW-1:0] z,
    input logic [LvW-1:0] depth, input logic [LvW-1:0] lv);
    logic [LvW-1:0]    p;
    logic [CoordW-1:0] xs, ys, zs;
    p  = depth - lv - 1'b1;
    xs = x >> {p, 1'b0};
    ys = y >> {p, 1'b0};
    zs = z >> {p, 1'b0};
    return {zs[1], ys[1], xs[1], zs[0], ys[0], xs[0]};
  endfunction

endpackage

[hdl/sparse_voxel_64_tree_store_core.sv]
// Top level of the sparse voxel tree store: controller plus datapath.
// Depends on svt_pkg, svt_ctrl, svt_dp (and svt_ram through svt_dp).
//
// Sparse voxel store, a tree with 64 children per node held in a 4096 entry
// node memory that grows by bump allocation. One command beat in, one result
// beat out. Items are handled one at a time: accept, decode, then per tree
// level plus the leaf a memory read and an evaluate step (up to 5 levels),
// then the result is handed to the output register. Each child block
// allocated by an insert is cleared one entry per cycle through the single
// write port; a completed insert then sets one mask bit per level. After
// reset and on a clear command the root is rewritten. The result sits in an
// output register, so a new command is taken while an earlier result waits.
// grid_resolution is to be written on the cfg channel only while the block
// is idle; the user is bound to this, the block itself does not enforce it.
module sparse_voxel_64_tree_store_core (
  input  logic        clk,
  input  logic        rst,
  // cmd[1:0], coord_x[11:2], coord_y[21:12], coord_z[31:22],
  // material_in[63:32], density_in[79:64]
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status[1:0], found[2], material_out[34:3], density_out[49:35], zero pad
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // grid_resolution
  input  logic [10:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import svt_pkg::*;

  svt_cmd_t  cmd;
  svt_stat_t stat;

  assign cfg_ready = 1'b1; // register write always taken

  svt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat, .cmd
  );

  svt_dp u_dp (
    .clk, .rst,
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_res   (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .cmd, .stat
  );
endmodule

[hdl/svt_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
module svt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/svt_ctrl.sv]
// Controller state machine of the voxel tree store.
// Depends on svt_pkg; drives svt_dp through svt_cmd_t.
module svt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  svt_pkg::svt_stat_t stat,
  output svt_pkg::svt_cmd_t  cmd
);
  import svt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        priority case (1'b1)
          stat.op == OP_CLEAR || stat.op == OP_NONE: state_next = S_FINISH;
          stat.op == OP_INSERT && stat.bad_insert:   state_next = S_FINISH;
          stat.op == OP_LOOKUP && stat.out_of_bounds: state_next = S_FINISH;
          default:                                   state_next = S_READ;
        endcase
      end
      S_READ:   state_next = S_EVAL;
      S_EVAL: begin
        if (stat.op == OP_LOOKUP) begin
          if (stat.lv_end || stat.miss) state_next = S_FINISH;
          else                          state_next = S_READ;
        end else if (stat.lv_end) begin
          state_next = stat.depth_zero ? S_FINISH : S_MASK;
        end else if (stat.no_base) begin
          state_next = stat.pool_full ? S_FINISH : S_CLEAR;
        end else begin
          state_next = S_READ;
        end
      end
      S_CLEAR:  if (stat.clr_last) state_next = S_READ;
      S_MASK:   if (stat.mask_last) state_next = S_FINISH;
      S_FINISH: if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res  = RES_DONE;
    in_ready = 1'b0;
    unique case (state)
      S_INIT:   cmd.root_init = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        priority case (1'b1)
          stat.op == OP_CLEAR: begin
            cmd.root_init = 1'b1;
            cmd.res       = RES_DONE;
          end
          stat.op == OP_NONE:                         cmd.res = RES_IGNORED;
          stat.op == OP_INSERT && stat.bad_insert:    cmd.res = RES_IGNORED;
          stat.op == OP_LOOKUP && stat.out_of_bounds: cmd.res = RES_IGNORED;
          default:                                    cmd.set_res = 1'b0;
        endcase
      end
      S_EVAL: begin
        if (stat.op == OP_LOOKUP) begin
          if (stat.lv_end) begin
            cmd.set_res = 1'b1;
            cmd.res     = stat.hit ? RES_HIT : RES_MISS;
          end else if (stat.miss) begin
            cmd.set_res = 1'b1;
            cmd.res     = RES_MISS;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (stat.lv_end) begin
          cmd.leaf_wr = 1'b1;
          cmd.set_res = stat.depth_zero;
          cmd.res     = RES_DONE;
        end else begin
          cmd.capture = 1'b1;
          if (stat.no_base) begin
            cmd.set_res = stat.pool_full;
            cmd.res     = RES_FULL;
            cmd.alloc   = !stat.pool_full;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step   = 1'b1;
        cmd.alloc_done = stat.clr_last;
      end
      S_MASK: begin
        cmd.mask_step = 1'b1;
        cmd.set_res   = stat.mask_last;
        cmd.res       = RES_DONE;
      end
      S_FINISH: cmd.push = stat.out_free;
      default: ;
    endcase
  end
endmodule

[hdl/svt_dp.sv]
// Datapath of the voxel tree store: node memories, walk registers, result.
// Depends on svt_pkg and svt_ram; controlled by svt_ctrl.
module svt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [svt_pkg::InW-1:0]     in_data,
  input  logic                        cfg_we,
  input  logic [svt_pkg::ResW-1:0]    cfg_res,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [svt_pkg::OutW-1:0]    out_data,
  input  svt_pkg::svt_cmd_t           cmd,
  output svt_pkg::svt_stat_t          stat
);
  import svt_pkg::*;

  // Captured item
  logic [1:0]        op;
  logic [CoordW-1:0] cx, cy, cz;
  logic [MatW-1:0]   mat;
  logic [DensW-1:0]  dens;
  logic [ResW-1:0]   res;

  // Walk state
  logic [NodeW-1:0]  node;
  logic [LvW-1:0]    lv;
  logic [UsedW-1:0]  nodes_used;
  logic [NodeW-1:0]  alloc_base;
  logic [ChildW-1:0] clr_cnt;
  logic [LvW-1:0]    mask_cnt;
  logic [NodeW-1:0]  path_node [MaxLevels];
  logic [ChildW-1:0] path_child [MaxLevels];
  logic [Children-1:0] path_mask [MaxLevels];

  // Result
  logic [1:0]        r_status;
  logic              r_found;
  logic [MatW-1:0]   r_mat;
  logic [DensW-2:0]  r_dens;

  logic [LvW-1:0]    depth;
  logic [ChildW-1:0] cidx;
  logic              in_grid;

  // Memories
  logic                 mask_we, base_we, leaf_we;
  logic [NodeW-1:0]     mask_wa, base_wa, leaf_wa;
  logic [Children-1:0]  mask_wd, mask_rd;
  logic [UsedW-1:0]     base_wd, base_rd;
  logic [MatW+DensW-1:0] leaf_wd, leaf_rd;
  logic [NodeW-1:0]     clr_addr;
  logic [NodeW:0]       reach;
  logic [MatW-1:0]      rd_mat;
  logic [DensW-1:0]     rd_dens;

  assign depth    = level_count(res);
  assign cidx     = child_index(cx, cy, cz, depth, lv);
  assign in_grid  = ResW'(cx) < res && ResW'(cy) < res && ResW'(cz) < res;
  assign clr_addr = alloc_base + NodeW'(clr_cnt);
  assign reach    = (NodeW+1)'(base_rd) + (NodeW+1)'(cidx);
  assign rd_mat   = leaf_rd[MatW-1:0];
  assign rd_dens  = leaf_rd[MatW+DensW-1:MatW];

  assign stat.op            = op_t'(op);
  assign stat.out_of_bounds = !in_grid;
  assign stat.bad_insert    = !in_grid || dens[DensW-1] || dens == '0;
  assign stat.lv_end        = lv == depth;
  assign stat.depth_zero    = depth == '0;
  assign stat.no_base       = base_rd == NoChild;
  assign stat.pool_full     = nodes_used > FullMark;
  assign stat.miss          = !mask_rd[cidx] || base_rd == NoChild || reach[NodeW];
  assign stat.hit           = !rd_dens[DensW-1] && rd_dens != '0;
  assign stat.clr_last      = clr_cnt == ChildW'(Children - 1);
  assign stat.mask_last     = mask_cnt == depth - 1'b1;
  assign stat.out_free      = !out_valid || out_ready;

  always_comb begin
    mask_we = 1'b0; mask_wa = '0; mask_wd = '0;
    base_we = 1'b0; base_wa = '0; base_wd = NoChild;
    leaf_we = 1'b0; leaf_wa = '0; leaf_wd = '0;
    if (cmd.root_init) begin
      mask_we = 1'b1; base_we = 1'b1; leaf_we = 1'b1;
    end else if (cmd.clr_step) begin
      mask_we = 1'b1; base_we = 1'b1; leaf_we = 1'b1;
      mask_wa = clr_addr; base_wa = clr_addr; leaf_wa = clr_addr;
    end else begin
      if (cmd.alloc) begin
        base_we = 1'b1;
        base_wa = node;
        base_wd = nodes_used;
      end
      if (cmd.leaf_wr) begin
        leaf_we = 1'b1;
        leaf_wa = node;
        leaf_wd = {dens, mat};
      end
      if (cmd.mask_step) begin
        mask_we = 1'b1;
        mask_wa = path_node[mask_cnt];
        mask_wd = path_mask[mask_cnt] | (Children'(1) << path_child[mask_cnt]);
      end
    end
  end

  svt_ram #(.Width(Children), .Depth(NodeCap)) u_mask (
    .clk, .we(mask_we), .waddr(mask_wa), .wdata(mask_wd), .raddr(node), .rdata(mask_rd));
  svt_ram #(.Width(UsedW), .Depth(NodeCap)) u_base (
    .clk, .we(base_we), .waddr(base_wa), .wdata(base_wd), .raddr(node), .rdata(base_rd));
  svt_ram #(.Width(MatW+DensW), .Depth(NodeCap)) u_leaf (
    .clk, .we(leaf_we), .waddr(leaf_wa), .wdata(leaf_wd), .raddr(node), .rdata(leaf_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      res        <= ResReset;
      nodes_used <= UsedW'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) res <= cfg_res;
      if (cmd.root_init)  nodes_used <= UsedW'(1);
      if (cmd.alloc_done) nodes_used <= nodes_used + UsedW'(Children);
      if (cmd.push)           out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_data[1:0];
      cx   <= in_data[11:2];
      cy   <= in_data[21:12];
      cz   <= in_data[31:22];
      mat  <= in_data[63:32];
      dens <= in_data[79:64];
      node <= '0;
      lv   <= '0;
      mask_cnt <= '0;
    end
    if (cmd.capture) begin
      path_node[lv]  <= node;
      path_child[lv] <= cidx;
      path_mask[lv]  <= mask_rd;
    end
    if (cmd.alloc) begin
      alloc_base <= nodes_used[NodeW-1:0];
      clr_cnt    <= '0;
    end
    if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
    if (cmd.alloc_done) begin
      node <= alloc_base + NodeW'(cidx);
      lv   <= lv + 1'b1;
    end
    if (cmd.advance) begin
      node <= reach[NodeW-1:0];
      lv   <= lv + 1'b1;
    end
    if (cmd.mask_step) mask_cnt <= mask_cnt + 1'b1;
    if (cmd.set_res) begin
      r_found <= 1'b0;
      r_mat   <= '0;
      r_dens  <= '0;
      unique case (cmd.res)
        RES_IGNORED: r_status <= ST_IGNORED;
        RES_FULL:    r_status <= ST_FULL;
        RES_HIT: begin
          r_status <= ST_DONE;
          r_found  <= 1'b1;
          r_mat    <= rd_mat;
          r_dens   <= rd_dens[DensW-2:0];
        end
        default:     r_status <= ST_DONE;
      endcase
    end
    if (cmd.push) out_data <= {6'b0, r_dens, r_mat, r_found, r_status};
  end
endmodule

[tb/sv/tb_top.sv]
// Testbench for sparse_voxel_64_tree_store_core: directed and random command beats,
// a behavioural tree model in a scoreboard class. Depends on svt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import svt_pkg::*;

  localparam int NCap = 4096;
  localparam int LimitCycles = 2000000;

  typedef struct packed {
    logic [14:0] dens;
    logic [31:0] mat;
    logic        found;
    logic [1:0]  status;
  } voxel_res_t;

  // Behavioural voxel tree plus queue of pending results
  class voxel_tree_board;
    logic [63:0] mask[NCap];
    int          base[NCap];
    logic [31:0] mat[NCap];
    int          dens[NCap];
    int          used;
    int          res;
    voxel_res_t  pending[$];
    int          errors;

    function new();
      errors = 0;
      res = 1024;
      wipe_node(0);
      used = 1;
    endfunction

    function void wipe_node(int n);
      mask[n] = '0; base[n] = -1; mat[n] = '0; dens[n] = 0;
    endfunction

    function int depth_of();
      int d, sz;
      d = 0; sz = 1;
      if (res == 0) return 0;
      while (sz < res && d < MaxLevels) begin
        sz *= 4; d++;
      end
      return d;
    endfunction

    function int cidx(int x, int y, int z, int d, int lv);
      int s;
      s = 2 * (d - 1 - lv);
      return ((x >> s) & 1) | (((y >> s) & 1) << 1) | (((z >> s) & 1) << 2) |
             (((x >> (s+1)) & 1) << 3) | (((y >> (s+1)) & 1) << 4) |
             (((z >> (s+1)) & 1) << 5);
    endfunction

    // Note an accepted command beat and predict its result
    function void note_command(logic [79:0] d);
      op_t op;
      int x, y, z, dn, dep, node, c, b, lv;
      int pn[MaxLevels], pc[MaxLevels];
      logic [31:0] m;
      bit inb, full, hit;
      voxel_res_t r;
      op = op_t'(d[1:0]);
      x = int'(d[11:2]); y = int'(d[21:12]); z = int'(d[31:22]);
      m = d[63:32]; dn = int'($signed(d[79:64]));
      dep = depth_of();
      inb = x < res && y < res && z < res;
      r = '0; node = 0;
      case (op)
        OP_INSERT: begin
          if (!inb || dn <= 0) r.status = ST_IGNORED;
          else begin
            full = 1'b0;
            for (lv = 0; lv < dep; lv++) begin
              c = cidx(x, y, z, dep, lv);
              b = base[node];
              pn[lv] = node; pc[lv] = c;
              if (b < 0) begin
                if (used > NCap - 64) begin
                  full = 1'b1; break;
                end
                b = used;
                for (int i = 0; i < 64; i++) wipe_node(b + i);
                used += 64;
                base[node] = b;
              end
              node = b + c;
            end
            if (full) r.status = ST_FULL;
            else begin
              mat[node] = m; dens[node] = dn;
              for (lv = 0; lv < dep; lv++) mask[pn[lv]][pc[lv]] = 1'b1;
            end
          end
        end
        OP_LOOKUP: begin
          if (!inb) r.status = ST_IGNORED;
          else begin
            hit = 1'b1;
            for (lv = 0; lv < dep; lv++) begin
              c = cidx(x, y, z, dep, lv);
              b = base[node];
              if (!mask[node][c] || b < 0 || b + c >= NCap) begin
                hit = 1'b0; break;
              end
              node = b + c;
            end
            if (hit && dens[node] > 0) begin
              r.found = 1'b1; r.mat = mat[node]; r.dens = dens[node][14:0];
            end
          end
        end
        OP_CLEAR: begin
          wipe_node(0); used = 1;
        end
        default: r.status = ST_IGNORED;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic [55:0] d);
      voxel_res_t got, want;
      got = d[49:0];
      if (pending.size() == 0) begin
        $display("%0t: result beat with none expected, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d actual %0d", $realtime, want.found, got.found);
        errors++;
      end
      if (got.mat !== want.mat) begin
        $display("%0t: material expected %h actual %h", $realtime, want.mat, got.mat);
        errors++;
      end
      if (got.dens !== want.dens) begin
        $display("%0t: density expected %h actual %h", $realtime, want.dens, got.dens);
        errors++;
      end
      if (d[55:50] !== '0) begin
        $display("%0t: pad expected 0 actual %h", $realtime, d[55:50]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  voxel_tree_board board;
  int  cycle_count = 0;
  bit  calm = 1'b0;       // no idling on either side
  bit  hold_sink = 1'b0;  // long receiver hold-off

  sparse_voxel_64_tree_store_core i_dut (
    .clk, .rst, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_data, .cfg_valid, .cfg_ready
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("FAIL sparse_voxel_64_tree_store_core");
      $finish;
    end
  end

  // Result side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  always @(negedge clk) begin
    if (rst || hold_sink) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 25);
  end

  // One command beat; random gap first
  task automatic send_beat(input logic [79:0] d);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 25) @(negedge clk);
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_command(d);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [79:0] pack_cmd(op_t op, int x, int y, int z,
                                           logic [31:0] m, logic [15:0] dn);
    return {dn, m, 10'(z), 10'(y), 10'(x), op};
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_res(input int r);
    @(negedge clk);
    cfg_data <= 11'(r);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.res = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random coordinate, mostly inside the grid, sometimes out of it
  function automatic int rand_coord(int r);
    if (r == 0 || $urandom_range(9) == 0) return $urandom_range(1023);
    if ($urandom_range(9) == 0) return r - 1;
    return $urandom_range(r - 1);
  endfunction

  task automatic random_phase(input int count, input int r);
    int xs[8], ys[8], zs[8];
    int k, pick, x, y, z;
    logic [15:0] dn;
    op_t op;
    for (int i = 0; i < 8; i++) begin
      xs[i] = rand_coord(r); ys[i] = rand_coord(r); zs[i] = rand_coord(r);
    end
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) op = OP_INSERT;
      else if (pick < 90) op = OP_LOOKUP;
      else if (pick < 93) op = OP_CLEAR;
      else if (pick < 95) op = OP_NONE;
      else op = op_t'($urandom_range(1));
      // reuse earlier coordinates so lookups hit
      if ($urandom_range(1)) begin
        pick = $urandom_range(7); x = xs[pick]; y = ys[pick]; z = zs[pick];
      end else begin
        x = rand_coord(r); y = rand_coord(r); z = rand_coord(r);
        pick = $urandom_range(7); xs[pick] = x; ys[pick] = y; zs[pick] = z;
      end
      dn = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32767, 1));
      send_beat(pack_cmd(op, x, y, z, $urandom, dn));
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes at reset resolution
    send_beat(pack_cmd(OP_LOOKUP, 0, 0, 0, 0, 0));
    send_beat(pack_cmd(OP_INSERT, 0, 0, 0, 32'hFFFF_FFFF, 16'h7FFF));
    send_beat(pack_cmd(OP_INSERT, 1023, 1023, 1023, 32'hA5A5_5A5A, 16'h0001));
    send_beat(pack_cmd(OP_LOOKUP, 0, 0, 0, 0, 0));
    send_beat(pack_cmd(OP_LOOKUP, 1023, 1023, 1023, 0, 0));
    send_beat(pack_cmd(OP_LOOKUP, 1023, 1023, 1022, 0, 0));
    send_beat(pack_cmd(OP_INSERT, 5, 6, 7, 32'h1234, 16'h0000));   // zero density
    send_beat(pack_cmd(OP_INSERT, 5, 6, 7, 32'h1234, 16'h8000));   // negative
    send_beat(pack_cmd(OP_INSERT, 5, 6, 7, 32'h1234, 16'hFFFF));
    send_beat(pack_cmd(OP_LOOKUP, 5, 6, 7, 0, 0));
    send_beat(pack_cmd(OP_NONE, 1, 2, 3, 32'hFFFF_FFFF, 16'hFFFF));
    send_beat(pack_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    send_beat(pack_cmd(OP_LOOKUP, 0, 0, 0, 0, 0));
    drain();

    // Resolution zero: everything out of bounds
    write_res(0);
    send_beat(pack_cmd(OP_INSERT, 0, 0, 0, 1, 16'h0100));
    send_beat(pack_cmd(OP_LOOKUP, 0, 0, 0, 0, 0));
    drain();
    // Resolution one: root is the leaf
    write_res(1);
    send_beat(pack_cmd(OP_INSERT, 0, 0, 0, 32'h77, 16'h0200));
    send_beat(pack_cmd(OP_LOOKUP, 0, 0, 0, 0, 0));
    send_beat(pack_cmd(OP_LOOKUP, 1, 0, 0, 0, 0));
    drain();
    // Maximum resolution, levels saturate; changed over existing data
    write_res(2047);
    send_beat(pack_cmd(OP_LOOKUP, 0, 0, 0, 0, 0));
    send_beat(pack_cmd(OP_INSERT, 1023, 0, 512, 32'h99, 16'h0300));
    send_beat(pack_cmd(OP_LOOKUP, 1023, 0, 512, 0, 0));
    drain();

    // Pool exhaustion: full-depth inserts at scattered coordinates
    write_res(1024);
    send_beat(pack_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    calm = 1'b1;
    for (int i = 0; i < 20; i++)
      send_beat(pack_cmd(OP_INSERT, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(1023), $urandom, 16'($urandom_range(32767, 1))));
    calm = 1'b0;
    drain();

    // Receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      random_phase(30, 1024);
    join
    drain();

    write_res(16);
    random_phase(150, 16);
    drain();
    write_res(64);
    random_phase(150, 64);
    drain();
    write_res(5);
    random_phase(100, 5);
    drain();
    write_res(1024);
    random_phase(200, 1024);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS sparse_voxel_64_tree_store_core");
    else
      $display("FAIL sparse_voxel_64_tree_store_core");
    $finish;
  end

endmodule

[sim.f]
hdl/svt_pkg.sv
hdl/svt_ram.sv
hdl/svt_ctrl.sv
hdl/svt_dp.sv
hdl/sparse_voxel_64_tree_store_core.sv
tb/sv/tb_top.sv
